/* hdl/ectc_pkg.sv */
// Shared types, constants and tables for the epoch to RTC calendar converter.
package ectc_pkg;

   // Register stages of each unit; the day and date units together set the overall depth.
   localparam int DAY_LAT  = 4;
   localparam int DATE_LAT = 11;
   localparam int CLK_LAT  = 5;
   localparam int PIPE_LAT = DAY_LAT + DATE_LAT;
   localparam int TOD_TAPS = DATE_LAT - CLK_LAT + 1;

   localparam int SECS_PER_MIN  = 60;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_DAY  = 86400;
   localparam int DAY_SHIFT     = 7;
   localparam int DAY_DIV       = SECS_PER_DAY >> DAY_SHIFT;

   // Reciprocals for the constant divisions; each estimate is low by at most one.
   localparam int DAY_RECIP   = 6362914;
   localparam int HOUR_RECIP  = 1165;
   localparam int MIN_RECIP   = 1092;
   localparam int WEEK_RECIP  = 74898;
   localparam int QUAD_RECIP  = 183859;
   localparam int YEAR_RECIP  = 367719;
   localparam int MONTH_RECIP = 428;

   localparam int DAYS_TO_EPOCH = 719468;
   localparam int ERA_DAYS      = 146097;
   localparam int MAX_ERA       = 5;
   localparam int CENT_DAYS     = 36524;
   localparam int QUAD_DAYS     = 1460;
   localparam int YEAR_DAYS     = 365;
   localparam int ERA_YEARS     = 400;
   localparam int MONTH_SPAN    = 153;
   localparam int DAYS_PER_WEEK = 7;
   localparam int WDAY_BIAS     = 3;
   localparam int FIRST_YEAR    = 2000;
   localparam int LAST_YEAR     = 2099;
   localparam int ZONE_RESET    = 8;

   typedef struct packed {
      logic        neg;
      logic [15:0] days;
      logic [16:0] sod;
   } day_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   typedef struct packed {
      logic [2:0] dow;
      logic [3:0] month;
      logic [4:0] mday;
      logic [6:0] yic;
      logic       yvalid;
   } date_type;

   // First day of each month in a year that starts on March 1.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start;
      unique case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

/* hdl/ectc_req_if.sv */
// Request channel carrying one timestamp item.
interface ectc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source(output valid, output epoch_seconds, input ready);
   modport sink(input valid, input epoch_seconds, output ready);
endinterface

/* hdl/ectc_rsp_if.sv */
// Response channel carrying one calendar item.
interface ectc_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] hour_of_day;
   logic [5:0] minute_of_hour;
   logic [5:0] second_of_minute;
   logic [2:0] day_of_week;
   logic [3:0] month_of_year;
   logic [4:0] day_of_month;
   logic [6:0] year_in_century;
   logic       year_valid;

   modport source(output valid, output hour_of_day, output minute_of_hour,
                  output second_of_minute, output day_of_week, output month_of_year,
                  output day_of_month, output year_in_century, output year_valid,
                  input ready);
   modport sink(input valid, input hour_of_day, input minute_of_hour,
                input second_of_minute, input day_of_week, input month_of_year,
                input day_of_month, input year_in_century, input year_valid,
                output ready);
endinterface

/* hdl/epoch_to_rtc_calendar.sv */
// Top level: Unix timestamp to local RTC calendar fields.
// Each item passes through a register pipeline to a valid result, and a new timestamp can be
// accepted every cycle; the depth is set by the day-count to date chain of constant
// reciprocal multiplies, each followed by a one-step correction. The whole pipeline
// advances together, so it holds only while a finished result is not taken. The signed
// hour offset in csr_wr_data resets to +8 and is added before the date is formed, so
// every field rolls over together. Years outside 2000..2099 report year 0 with
// year_valid low while the other fields remain correct.
module epoch_to_rtc_calendar import ectc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ectc_req_if.sink    req_ch,
   ectc_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   logic signed [4:0]   zone_ff;
   logic [PIPE_LAT-1:0] valid_ff;
   logic                advance;
   day_type             day;
   tod_type             tod;
   date_type            date;

   assign advance = !valid_ff[PIPE_LAT-1] || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff  <= 5'(ZONE_RESET);
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            zone_ff <= csr_wr_data;
         end
         if (advance) begin
            valid_ff <= {valid_ff[PIPE_LAT-2:0], req_ch.valid};
         end
      end
   end

   ectc_day_split u_day_split (
      .clock             (clock),
      .advance           (advance),
      .epoch_seconds     (req_ch.epoch_seconds),
      .zone_offset_hours (zone_ff),
      .day_out           (day)
   );

   ectc_clock_split u_clock_split (
      .clock   (clock),
      .advance (advance),
      .sod     (day.sod),
      .tod_out (tod)
   );

   ectc_date u_date (
      .clock    (clock),
      .advance  (advance),
      .neg      (day.neg),
      .days     (day.days),
      .date_out (date)
   );

   assign req_ch.ready            = advance;
   assign rsp_ch.valid            = valid_ff[PIPE_LAT-1];
   assign rsp_ch.hour_of_day      = tod.hour;
   assign rsp_ch.minute_of_hour   = tod.minute;
   assign rsp_ch.second_of_minute = tod.second;
   assign rsp_ch.day_of_week      = date.dow;
   assign rsp_ch.month_of_year    = date.month;
   assign rsp_ch.day_of_month     = date.mday;
   assign rsp_ch.year_in_century  = date.yic;
   assign rsp_ch.year_valid       = date.yvalid;

endmodule

/* hdl/ectc_day_split.sv */
// Applies the zone offset and splits local seconds into whole days and seconds of day.
module ectc_day_split import ectc_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic [31:0]       epoch_seconds,
   input  logic signed [4:0] zone_offset_hours,
   output day_type           day_out
);

   logic signed [16:0] zone_secs;
   logic signed [33:0] local_in;

   logic        s1_neg_ff;
   logic [25:0] s1_quot_ff;
   logic [6:0]  s1_low7_ff;
   logic [16:0] s1_low17_ff;

   logic [48:0] qprod;
   logic        s2_neg_ff;
   logic [25:0] s2_quot_ff;
   logic [6:0]  s2_low7_ff;
   logic [16:0] s2_qe_ff;
   logic [16:0] s2_nsod_ff;

   logic [26:0] s3_prod_in;
   logic        s3_neg_ff;
   logic [25:0] s3_quot_ff;
   logic [6:0]  s3_low7_ff;
   logic [16:0] s3_qe_ff;
   logic [16:0] s3_nsod_ff;
   logic [26:0] s3_prod_ff;

   logic [25:0] rem_raw;
   logic        rem_over;
   logic [9:0]  rem_fix;
   day_type     day_in;
   day_type     day_ff;

   always_comb begin
      zone_secs = 17'($signed({{12{zone_offset_hours[4]}}, zone_offset_hours})
                      * $signed(17'(SECS_PER_HOUR)));
      local_in  = $signed({2'b00, epoch_seconds}) + 34'(zone_secs);
      qprod      = 49'(s1_quot_ff) * 49'(DAY_RECIP);
      s3_prod_in = 27'(s2_qe_ff) * 27'(DAY_DIV);
      rem_raw  = s3_quot_ff - 26'(s3_prod_ff);
      rem_over = rem_raw >= 26'(DAY_DIV);
      rem_fix  = 10'(rem_over ? rem_raw - 26'(DAY_DIV) : rem_raw);
      day_in.neg  = s3_neg_ff;
      day_in.days = 16'(s3_qe_ff + 17'(rem_over));
      // A negative local time is always the last day of 1969.
      day_in.sod  = s3_neg_ff ? s3_nsod_ff : {rem_fix, s3_low7_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_neg_ff   <= local_in[33];
         s1_quot_ff  <= local_in[32:7];
         s1_low7_ff  <= local_in[6:0];
         s1_low17_ff <= local_in[16:0];

         s2_neg_ff  <= s1_neg_ff;
         s2_quot_ff <= s1_quot_ff;
         s2_low7_ff <= s1_low7_ff;
         s2_qe_ff   <= qprod[48:32];
         s2_nsod_ff <= s1_low17_ff + 17'(SECS_PER_DAY);

         s3_neg_ff  <= s2_neg_ff;
         s3_quot_ff <= s2_quot_ff;
         s3_low7_ff <= s2_low7_ff;
         s3_qe_ff   <= s2_qe_ff;
         s3_nsod_ff <= s2_nsod_ff;
         s3_prod_ff <= s3_prod_in;

         day_ff <= day_in;
      end
   end

   assign day_out = day_ff;

endmodule

/* hdl/ectc_clock_split.sv */
// Splits seconds of day into hour, minute and second, delayed to meet the date path.
module ectc_clock_split import ectc_pkg::*; (
   input  logic        clock,
   input  logic        advance,
   input  logic [16:0] sod,
   output tod_type     tod_out
);

   logic [27:0] hprod;
   logic [16:0] c1_sod_ff;
   logic [4:0]  c1_hest_ff;

   logic [16:0] c2_sod_ff;
   logic [4:0]  c2_hest_ff;
   logic [16:0] c2_ph_ff;

   logic [16:0] hrem_raw;
   logic        hrem_over;
   logic [4:0]  c3_hour_in;
   logic [11:0] c3_rem_in;
   logic [4:0]  c3_hour_ff;
   logic [11:0] c3_rem_ff;

   logic [22:0] mprod;
   logic [4:0]  c4_hour_ff;
   logic [11:0] c4_rem_ff;
   logic [5:0]  c4_mest_ff;

   logic [11:0] mrem_raw;
   logic        mrem_over;
   tod_type     tod_in;
   tod_type     tod_dly_ff [TOD_TAPS];

   always_comb begin
      hprod      = 28'(sod) * 28'(HOUR_RECIP);
      hrem_raw   = c2_sod_ff - c2_ph_ff;
      hrem_over  = hrem_raw >= 17'(SECS_PER_HOUR);
      c3_hour_in = c2_hest_ff + 5'(hrem_over);
      c3_rem_in  = 12'(hrem_over ? hrem_raw - 17'(SECS_PER_HOUR) : hrem_raw);
      mprod      = 23'(c3_rem_ff) * 23'(MIN_RECIP);
      mrem_raw   = c4_rem_ff - 12'(c4_mest_ff) * 12'(SECS_PER_MIN);
      mrem_over  = mrem_raw >= 12'(SECS_PER_MIN);
      tod_in.hour   = c4_hour_ff;
      tod_in.minute = c4_mest_ff + 6'(mrem_over);
      tod_in.second = 6'(mrem_over ? mrem_raw - 12'(SECS_PER_MIN) : mrem_raw);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_sod_ff  <= sod;
         c1_hest_ff <= hprod[26:22];

         c2_sod_ff  <= c1_sod_ff;
         c2_hest_ff <= c1_hest_ff;
         c2_ph_ff   <= 17'(c1_hest_ff) * 17'(SECS_PER_HOUR);

         c3_hour_ff <= c3_hour_in;
         c3_rem_ff  <= c3_rem_in;

         c4_hour_ff <= c3_hour_ff;
         c4_rem_ff  <= c3_rem_ff;
         c4_mest_ff <= mprod[21:16];

         tod_dly_ff[0] <= tod_in;
         for (int i = 1; i < TOD_TAPS; i++) begin
            tod_dly_ff[i] <= tod_dly_ff[i-1];
         end
      end
   end

   assign tod_out = tod_dly_ff[TOD_TAPS-1];

endmodule

/* hdl/ectc_date.sv */
// Maps a day count to weekday, month, day of month and year in century.
module ectc_date import ectc_pkg::*; (
   input  logic        clock,
   input  logic        advance,
   input  logic        neg,
   input  logic [15:0] days,
   output date_type    date_out
);

   // D1
   logic [19:0] d1_z_ff;
   logic [15:0] d1_u_ff;
   // D2
   logic [2:0]  era_in;
   logic [32:0] wprod;
   logic [2:0]  d2_era_ff;
   logic [17:0] d2_doe_ff;
   logic [15:0] d2_u_ff;
   logic [12:0] d2_west_ff;
   // D3
   logic [15:0] wrem_raw;
   logic [3:0]  wrem;
   logic [2:0]  dow_in;
   logic [35:0] aprod;
   logic [2:0]  cent_in;
   logic [2:0]  d3_era_ff;
   logic [17:0] d3_doe_ff;
   logic [2:0]  d3_dow_ff;
   logic [6:0]  d3_aest_ff;
   logic [2:0]  d3_b_ff;
   logic        d3_c_ff;
   // D4
   logic [17:0] arem;
   logic [2:0]  d4_era_ff;
   logic [17:0] d4_doe_ff;
   logic [2:0]  d4_dow_ff;
   logic [6:0]  d4_a_ff;
   logic [2:0]  d4_b_ff;
   logic        d4_c_ff;
   // D5
   logic [2:0]  d5_era_ff;
   logic [17:0] d5_doe_ff;
   logic [2:0]  d5_dow_ff;
   logic [17:0] d5_t_ff;
   // D6
   logic [36:0] yprod;
   logic [2:0]  d6_era_ff;
   logic [17:0] d6_doe_ff;
   logic [2:0]  d6_dow_ff;
   logic [17:0] d6_t_ff;
   logic [8:0]  d6_yest_ff;
   // D7
   logic [17:0] yrem;
   logic [2:0]  d7_era_ff;
   logic [17:0] d7_doe_ff;
   logic [2:0]  d7_dow_ff;
   logic [8:0]  d7_yoe_ff;
   // D8
   logic [1:0]  yc_in;
   logic [8:0]  doy_in;
   logic [8:0]  d8_doy_ff;
   logic [11:0] d8_ybase_ff;
   logic [2:0]  d8_dow_ff;
   // D9
   logic [10:0] n9;
   logic [19:0] mprod;
   logic [8:0]  d9_doy_ff;
   logic [11:0] d9_ybase_ff;
   logic [2:0]  d9_dow_ff;
   logic [3:0]  d9_mest_ff;
   // D10
   logic [10:0] n10;
   logic [10:0] mrem;
   logic [8:0]  d10_doy_ff;
   logic [11:0] d10_ybase_ff;
   logic [2:0]  d10_dow_ff;
   logic [3:0]  d10_mp_ff;
   // D11
   logic        late_month;
   logic [11:0] year_full;
   logic        in_range;
   date_type    date_in;
   date_type    date_ff;

   always_comb begin
      era_in = '0;
      for (int i = 1; i <= MAX_ERA; i++) begin
         if (d1_z_ff >= 20'(i * ERA_DAYS)) begin
            era_in = 3'(i);
         end
      end
      wprod = 33'(d1_u_ff) * 33'(WEEK_RECIP);

      wrem_raw = d2_u_ff - 16'(d2_west_ff) * 16'(DAYS_PER_WEEK);
      wrem     = wrem_raw[3:0];
      dow_in   = 3'((wrem >= 4'(DAYS_PER_WEEK)) ? wrem - 4'(DAYS_PER_WEEK) : wrem) + 3'd1;
      aprod    = 36'(d2_doe_ff) * 36'(QUAD_RECIP);
      cent_in  = '0;
      for (int k = 1; k <= 4; k++) begin
         if (d2_doe_ff >= 18'(k * CENT_DAYS)) begin
            cent_in = 3'(k);
         end
      end

      arem  = d3_doe_ff - 18'(d3_aest_ff) * 18'(QUAD_DAYS);
      yprod = 37'(d5_t_ff) * 37'(YEAR_RECIP);
      yrem  = d6_t_ff - 18'(d6_yest_ff) * 18'(YEAR_DAYS);

      yc_in = '0;
      for (int k = 1; k <= 3; k++) begin
         if (d7_yoe_ff >= 9'(k * 100)) begin
            yc_in = 2'(k);
         end
      end
      doy_in = 9'(d7_doe_ff - (18'(d7_yoe_ff) * 18'(YEAR_DAYS) + 18'(d7_yoe_ff >> 2)
                               - 18'(yc_in)));

      n9    = 11'(d8_doy_ff) * 11'd5 + 11'd2;
      mprod = 20'(n9) * 20'(MONTH_RECIP);
      n10   = 11'(d9_doy_ff) * 11'd5 + 11'd2;
      mrem  = n10 - 11'(d9_mest_ff) * 11'(MONTH_SPAN);

      // January and February belong to the following calendar year.
      late_month   = d10_mp_ff >= 4'd10;
      year_full    = d10_ybase_ff + 12'(late_month);
      in_range     = (year_full >= 12'(FIRST_YEAR)) && (year_full <= 12'(LAST_YEAR));
      date_in.dow    = d10_dow_ff;
      date_in.month  = late_month ? d10_mp_ff - 4'd9 : d10_mp_ff + 4'd3;
      date_in.mday   = 5'(d10_doy_ff - month_start(d10_mp_ff) + 9'd1);
      date_in.yvalid = in_range;
      date_in.yic    = in_range ? 7'(year_full - 12'(FIRST_YEAR)) : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_z_ff <= neg ? 20'(DAYS_TO_EPOCH - 1) : 20'(days) + 20'(DAYS_TO_EPOCH);
         d1_u_ff <= neg ? 16'(WDAY_BIAS - 1) : days + 16'(WDAY_BIAS);

         d2_era_ff  <= era_in;
         d2_doe_ff  <= 18'(d1_z_ff - 20'(era_in) * 20'(ERA_DAYS));
         d2_u_ff    <= d1_u_ff;
         d2_west_ff <= wprod[31:19];

         d3_era_ff  <= d2_era_ff;
         d3_doe_ff  <= d2_doe_ff;
         d3_dow_ff  <= dow_in;
         d3_aest_ff <= aprod[34:28];
         d3_b_ff    <= cent_in;
         d3_c_ff    <= d2_doe_ff == 18'(ERA_DAYS - 1);

         d4_era_ff <= d3_era_ff;
         d4_doe_ff <= d3_doe_ff;
         d4_dow_ff <= d3_dow_ff;
         d4_a_ff   <= d3_aest_ff + 7'(arem >= 18'(QUAD_DAYS));
         d4_b_ff   <= d3_b_ff;
         d4_c_ff   <= d3_c_ff;

         d5_era_ff <= d4_era_ff;
         d5_doe_ff <= d4_doe_ff;
         d5_dow_ff <= d4_dow_ff;
         d5_t_ff   <= d4_doe_ff - 18'(d4_a_ff) + 18'(d4_b_ff) - 18'(d4_c_ff);

         d6_era_ff  <= d5_era_ff;
         d6_doe_ff  <= d5_doe_ff;
         d6_dow_ff  <= d5_dow_ff;
         d6_t_ff    <= d5_t_ff;
         d6_yest_ff <= yprod[35:27];

         d7_era_ff <= d6_era_ff;
         d7_doe_ff <= d6_doe_ff;
         d7_dow_ff <= d6_dow_ff;
         d7_yoe_ff <= d6_yest_ff + 9'(yrem >= 18'(YEAR_DAYS));

         d8_doy_ff   <= doy_in;
         d8_ybase_ff <= 12'(d7_yoe_ff) + 12'(d7_era_ff) * 12'(ERA_YEARS);
         d8_dow_ff   <= d7_dow_ff;

         d9_doy_ff   <= d8_doy_ff;
         d9_ybase_ff <= d8_ybase_ff;
         d9_dow_ff   <= d8_dow_ff;
         d9_mest_ff  <= mprod[19:16];

         d10_doy_ff   <= d9_doy_ff;
         d10_ybase_ff <= d9_ybase_ff;
         d10_dow_ff   <= d9_dow_ff;
         d10_mp_ff    <= d9_mest_ff + 4'(mrem >= 11'(MONTH_SPAN));

         date_ff <= date_in;
      end
   end

   assign date_out = date_ff;

endmodule

/* hdl/ectc_checker.sv */
// Port-level assertions for the calendar converter, bound to the top level.
module ectc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] hour_of_day,
   input logic [5:0] minute_of_hour,
   input logic [5:0] second_of_minute,
   input logic [2:0] day_of_week,
   input logic [3:0] month_of_year,
   input logic [4:0] day_of_month,
   input logic [6:0] year_in_century,
   input logic       year_valid
);

   // Every result carries fields inside their calendar ranges.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59)
                    && (second_of_minute <= 6'd59) && (day_of_week >= 3'd1)
                    && (day_of_week <= 3'd7) && (month_of_year >= 4'd1)
                    && (month_of_year <= 4'd12) && (day_of_month >= 5'd1)
                    && (year_in_century <= 7'd99))
      else $error("result field out of calendar range");

   // An out-of-range year reports year zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !year_valid) |-> (year_in_century == 7'd0))
      else $error("year_in_century nonzero while year_valid is low");

   // Without a waiting result the converter never refuses an item.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !rsp_valid) |-> req_ready)
      else $error("request stalled with no result pending");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(hour_of_day)
                                    && $stable(day_of_month) && $stable(year_in_century))
      else $error("stalled result changed");

endmodule

bind epoch_to_rtc_calendar ectc_checker u_ectc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .hour_of_day      (rsp_ch.hour_of_day),
   .minute_of_hour   (rsp_ch.minute_of_hour),
   .second_of_minute (rsp_ch.second_of_minute),
   .day_of_week      (rsp_ch.day_of_week),
   .month_of_year    (rsp_ch.month_of_year),
   .day_of_month     (rsp_ch.day_of_month),
   .year_in_century  (rsp_ch.year_in_century),
   .year_valid       (rsp_ch.year_valid)
);

/* tb/tb_epoch_to_rtc_calendar.sv */
// Self-checking testbench for the epoch to RTC calendar converter.
module tb_epoch_to_rtc_calendar;
   import ectc_pkg::*;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] dow;
      logic [3:0] month;
      logic [4:0] mday;
      logic [6:0] yic;
      logic       yvalid;
   } calendar_fields_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [4:0] csr_wr_data;

   ectc_req_if req_bus();
   ectc_rsp_if rsp_bus();

   epoch_to_rtc_calendar u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [31:0]      pending_epochs[$];
   calendar_fields_type expected_dates[$];
   logic signed [4:0] zone_hours = 5'sd8;
   int items_sent = 0;
   int results_seen = 0;
   int fail_count = 0;
   int send_gap = 0;
   bit send_burst = 0;
   int hold_left = 0;
   bit recv_burst = 0;
   int long_holds = 0;

   // Local calendar for a timestamp under a given whole-hour offset.
   function automatic calendar_fields_type to_local_calendar(logic [31:0] secs,
                                                             logic signed [4:0] zone);
      calendar_fields_type cal;
      longint local_secs, days, sod, z, era, doe, yoe, doy, mp, yr, mon, wd;
      local_secs = longint'(secs) + longint'(zone) * SECS_PER_HOUR;
      // Negative local time can only reach back into the last day of 1969.
      if (local_secs < 0) begin
         days = -1;
         sod  = local_secs + SECS_PER_DAY;
      end else begin
         days = local_secs / SECS_PER_DAY;
         sod  = local_secs % SECS_PER_DAY;
      end
      z   = days + DAYS_TO_EPOCH;
      era = z / ERA_DAYS;
      doe = z - era * ERA_DAYS;
      yoe = (doe - doe / QUAD_DAYS + doe / CENT_DAYS - doe / (ERA_DAYS - 1)) / YEAR_DAYS;
      doy = doe - (YEAR_DAYS * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / MONTH_SPAN;
      yr  = yoe + era * ERA_YEARS;
      mon = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2) yr = yr + 1;
      wd = ((days % DAYS_PER_WEEK) + DAYS_PER_WEEK + WDAY_BIAS) % DAYS_PER_WEEK + 1;
      cal.hour   = 5'(sod / SECS_PER_HOUR);
      cal.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
      cal.second = 6'(sod % SECS_PER_MIN);
      cal.dow    = 3'(wd);
      cal.month  = 4'(mon);
      cal.mday   = 5'(doy - (MONTH_SPAN * mp + 2) / 5 + 1);
      cal.yvalid = (yr >= FIRST_YEAR && yr <= LAST_YEAR);
      cal.yic    = cal.yvalid ? 7'(yr % 100) : 7'd0;
      return cal;
   endfunction

   // Mostly short gaps, a few long ones, none at all during a burst.
   function automatic int pick_gap(bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random timestamps weighted toward century, midnight and small-value corners.
   function automatic logic [31:0] pick_epoch();
      int r;
      longint base;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom();
      if (r < 55) base = 946684800;
      else if (r < 70) base = 4102444800;
      else if (r < 90) base = longint'($urandom_range(0, 49710)) * SECS_PER_DAY;
      else return $urandom_range(0, 200000);
      base = base + $signed($urandom_range(0, 2 * 172800)) - 172800;
      if (base < 0) base = 0;
      if (base > 32'hFFFF_FFFF) base = 32'hFFFF_FFFF;
      return base[31:0];
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic write_zone(logic signed [4:0] hours);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= hours;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      zone_hours = hours;
   endtask

   task automatic wait_drained();
      while (results_seen < items_sent || pending_epochs.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Driver: offers queued timestamps, with random data during send gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if ($urandom_range(0, 199) == 0) send_burst = !send_burst;
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid         <= 1'b0;
            req_bus.epoch_seconds <= $urandom();
         end else if (pending_epochs.size() > 0) begin
            req_bus.valid         <= 1'b1;
            req_bus.epoch_seconds <= pending_epochs.pop_front();
            send_gap = pick_gap(send_burst);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off while a backlog is waiting.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 199) == 0) recv_burst = !recv_burst;
         if (long_holds < 2 && pending_epochs.size() >= 60) begin
            hold_left = 400;
            long_holds++;
         end else begin
            hold_left = pick_gap(recv_burst);
         end
      end
   end

   // Monitor: predicts on each accepted timestamp and checks each taken result.
   always @(posedge clock) begin
      calendar_fields_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            expected_dates.push_back(to_local_calendar(req_bus.epoch_seconds, zone_hours));
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_dates.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual %0d:%0d:%0d",
                        $time, rsp_bus.hour_of_day, rsp_bus.minute_of_hour,
                        rsp_bus.second_of_minute);
            end else begin
               want = expected_dates.pop_front();
               check_field("hour_of_day", int'(want.hour), int'(rsp_bus.hour_of_day));
               check_field("minute_of_hour", int'(want.minute),
                           int'(rsp_bus.minute_of_hour));
               check_field("second_of_minute", int'(want.second),
                           int'(rsp_bus.second_of_minute));
               check_field("day_of_week", int'(want.dow), int'(rsp_bus.day_of_week));
               check_field("month_of_year", int'(want.month), int'(rsp_bus.month_of_year));
               check_field("day_of_month", int'(want.mday), int'(rsp_bus.day_of_month));
               check_field("year_in_century", int'(want.yic),
                           int'(rsp_bus.year_in_century));
               check_field("year_valid", int'(want.yvalid), int'(rsp_bus.year_valid));
            end
         end
      end
   end

   initial begin
      logic [31:0] corners[12];
      int zone_plan[8];
      int count_plan[8];
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      corners = '{32'd0, 32'd57599, 32'd57600, 32'd86399, 32'd946684799, 32'd946684800,
                  32'd951782400, 32'd1709164800, 32'd4102444799, 32'd4102444800,
                  32'h8000_0000, 32'hFFFF_FFFF};
      zone_plan  = '{15, -12, 14, 0, -1, 3, -16, 8};
      count_plan = '{40, 40, 40, 120, 40, 40, 40, 40};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Corner timestamps under the reset offset, then under the most negative one,
      // which pushes the earliest of them back into 1969.
      foreach (corners[i]) pending_epochs.push_back(corners[i]);
      items_sent += $size(corners);
      wait_drained();
      write_zone(5'(-16));
      foreach (corners[i]) pending_epochs.push_back(corners[i]);
      items_sent += $size(corners);
      wait_drained();

      foreach (zone_plan[p]) begin
         write_zone(5'(zone_plan[p]));
         for (int n = 0; n < count_plan[p]; n++) pending_epochs.push_back(pick_epoch());
         items_sent += count_plan[p];
         wait_drained();
      end

      repeat (PIPE_LAT + 5) @(posedge clock);
      if (fail_count == 0 && expected_dates.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/ectc_pkg.sv
hdl/ectc_req_if.sv
hdl/ectc_rsp_if.sv
hdl/ectc_day_split.sv
hdl/ectc_clock_split.sv
hdl/ectc_date.sv
hdl/epoch_to_rtc_calendar.sv
hdl/ectc_checker.sv
tb/tb_epoch_to_rtc_calendar.sv
